// ----- rtl/sdf_pkg.sv -----
// Shared constants and types for the sync packet deframer.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package sdf_pkg;

  // Default number of 16-bit samples in an ADC payload.
  localparam int unsigned ADC_SAMPLES_DEFAULT = 32;

  // Header and type byte values.
  localparam logic [7:0] SYNC_BYTE  = 8'h55;
  localparam logic [7:0] TYPE_BLOCK = 8'h20;
  localparam logic [7:0] TYPE_ADC   = 8'h00;

  // Block payload length in bytes, and the index of its final field.
  localparam int unsigned BLOCK_BYTES      = 52;
  localparam logic [5:0]  BLOCK_LAST_FIELD = 6'd28;

  // Packet kind codes carried with every result.
  localparam logic KIND_BLOCK = 1'b0;
  localparam logic KIND_ADC   = 1'b1;

  // One assembled field, as handed to the output buffer.
  typedef struct packed {
    logic        packet_kind;
    logic [5:0]  field_index;
    logic [63:0] field_value;
    logic        last_of_packet;
  } sdf_result_t;

endpackage

`default_nettype wire

// ----- rtl/sdf_parser.sv -----
// Byte parser of the sync packet deframer: header hunt, payload offset and field assembly.
// Depends on sdf_pkg for the header constants and the result type.
`timescale 1ns / 1ps
`default_nettype none

module sdf_parser #(
  parameter int unsigned ADC_SAMPLES = sdf_pkg::ADC_SAMPLES_DEFAULT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 byte_fire_i,
  input  wire logic [7:0]           byte_i,
  output logic                      res_push_o,
  output sdf_pkg::sdf_result_t      res_o
);
  import sdf_pkg::*;

  // Parse modes.
  localparam logic [1:0] ModeHunt  = 2'd0;
  localparam logic [1:0] ModeBlock = 2'd1;
  localparam logic [1:0] ModeAdc   = 2'd2;

  localparam logic [6:0] BlockLastOff = 7'(BLOCK_BYTES - 1);
  localparam logic [6:0] AdcLastOff   = 7'(2 * ADC_SAMPLES - 1);

  logic [1:0]  sync_seen_q, sync_seen_d;
  logic [1:0]  mode_q, mode_d;
  logic [6:0]  offset_q, offset_d;
  logic [63:0] acc_q, acc_d;

  logic [2:0]  pos;
  logic [63:0] acc_next;
  logic        last;

  // Byte position within the current field, from the payload offset.
  always_comb begin
    if (mode_q == ModeBlock && offset_q < 7'd24) begin
      pos = offset_q[2:0];
    end else begin
      pos = {2'b00, offset_q[0] & (mode_q == ModeAdc || offset_q < 7'd28)};
    end
  end

  // Little-endian assembly: the first byte of a field replaces the accumulator.
  assign acc_next = (pos == 3'd0) ? {56'd0, byte_i}
                                  : acc_q | ({56'd0, byte_i} << {pos, 3'b000});

  // Next state and result for one byte.
  always_comb begin
    sync_seen_d = sync_seen_q;
    mode_d      = mode_q;
    offset_d    = offset_q;
    acc_d       = acc_q;
    res_push_o  = 1'b0;
    res_o       = '0;
    last        = 1'b0;

    unique case (mode_q)
      ModeBlock: begin
        acc_d = acc_next;
        last  = offset_q >= BlockLastOff;
        if (last) begin
          mode_d   = ModeHunt;
          offset_d = '0;
        end else begin
          offset_d = offset_q + 7'd1;
        end
        res_o.packet_kind    = KIND_BLOCK;
        res_o.field_value    = acc_next;
        res_o.last_of_packet = last;
        if (offset_q < 7'd24) begin
          res_o.field_index = {4'd0, offset_q[4:3]};
          res_push_o        = (offset_q[2:0] == 3'd7);
        end else if (offset_q < 7'd28) begin
          res_o.field_index = 6'd3 + {5'd0, offset_q[1]};
          res_push_o        = offset_q[0];
        end else begin
          res_o.field_index = 6'(offset_q - 7'd23);
          res_push_o        = 1'b1;
        end
      end
      ModeAdc: begin
        acc_d = acc_next;
        last  = offset_q >= AdcLastOff;
        if (last) begin
          mode_d   = ModeHunt;
          offset_d = '0;
        end else begin
          offset_d = offset_q + 7'd1;
        end
        res_o.packet_kind    = KIND_ADC;
        res_o.field_index    = offset_q[6:1];
        res_o.field_value    = {48'd0, acc_next[15:0]};
        res_o.last_of_packet = last;
        res_push_o           = offset_q[0];
      end
      default: begin
        // Hunting; the unused mode code falls back here as well.
        mode_d = ModeHunt;
        if (sync_seen_q == 2'd3) begin
          if (byte_i == SYNC_BYTE) begin
            sync_seen_d = 2'd3;
          end else if (byte_i == TYPE_BLOCK) begin
            sync_seen_d = '0;
            mode_d      = ModeBlock;
            offset_d    = '0;
            acc_d       = '0;
          end else if (byte_i == TYPE_ADC) begin
            sync_seen_d = '0;
            mode_d      = ModeAdc;
            offset_d    = '0;
            acc_d       = '0;
          end else begin
            sync_seen_d = '0;
          end
        end else if (byte_i == SYNC_BYTE) begin
          sync_seen_d = sync_seen_q + 2'd1;
        end else begin
          sync_seen_d = '0;
        end
      end
    endcase

    if (!byte_fire_i) begin
      res_push_o = 1'b0;
    end
  end

  // Parser state, updated on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_seen_q <= '0;
      mode_q      <= ModeHunt;
      offset_q    <= '0;
      acc_q       <= '0;
    end else if (byte_fire_i) begin
      sync_seen_q <= sync_seen_d;
      mode_q      <= mode_d;
      offset_q    <= offset_d;
      acc_q       <= acc_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sdf_skid.sv -----
// Two-entry output buffer of the sync packet deframer: result register plus skid register.
// Depends on sdf_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module sdf_skid (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire sdf_pkg::sdf_result_t push_data_i,
  output logic                      full_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output sdf_pkg::sdf_result_t      out_data_o
);
  import sdf_pkg::*;

  logic        main_valid_q, main_valid_d;
  logic        skid_valid_q, skid_valid_d;
  sdf_result_t main_q, main_d;
  sdf_result_t skid_q, skid_d;
  logic        pop;

  assign pop         = main_valid_q && !out_stall_i;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;
  assign full_o      = skid_valid_q;

  // Refill the result register from the skid entry first to keep order.
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop || !main_valid_q) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        main_d       = push_data_i;
        main_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = push_data_i;
      skid_valid_d = 1'b1;
    end
  end

  // Control bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

// ----- rtl/sync_packet_deframer.sv -----
// Sync packet deframer takes one received byte per transfer and hunts for three 0x55 bytes
// and a type byte; type 0x20 opens a 52-byte block payload of 29 fields, type 0x00 an ADC
// payload of ADC_SAMPLES 16-bit samples, and each field is emitted little-endian on the byte
// that completes it. A byte is accepted in each cycle that rx_stall_o is low; its result, if
// any, is registered in the result register, or the skid register while that is held. A
// two-entry output buffer absorbs downstream stalls, so rx_stall_o rises only once both its
// entries hold results, and then for as long as the consumer keeps res_stall_i high.
// Depends on sdf_pkg, sdf_parser and sdf_skid.
`timescale 1ns / 1ps
`default_nettype none

module sync_packet_deframer #(
  parameter int unsigned ADC_SAMPLES = sdf_pkg::ADC_SAMPLES_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        rx_valid_i,
  output logic             rx_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             res_valid_o,
  input  wire logic        res_stall_i,
  output logic             packet_kind_o,
  output logic [5:0]       field_index_o,
  output logic [63:0]      field_value_o,
  output logic             last_of_packet_o
);
  import sdf_pkg::*;

  logic        rx_fire;
  logic        res_push;
  logic        buf_full;
  sdf_result_t res_new;
  sdf_result_t res_out;

  // Input transfer whenever the output buffer has a free entry.
  assign rx_stall_o = buf_full;
  assign rx_fire    = rx_valid_i && !rx_stall_o;

  sdf_parser #(
    .ADC_SAMPLES(ADC_SAMPLES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_fire_i(rx_fire),
    .byte_i     (rx_byte_i),
    .res_push_o (res_push),
    .res_o      (res_new)
  );

  sdf_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_push),
    .push_data_i(res_new),
    .full_o     (buf_full),
    .out_valid_o(res_valid_o),
    .out_stall_i(res_stall_i),
    .out_data_o (res_out)
  );

  // Result fields onto their ports.
  assign packet_kind_o    = res_out.packet_kind;
  assign field_index_o    = res_out.field_index;
  assign field_value_o    = res_out.field_value;
  assign last_of_packet_o = res_out.last_of_packet;

`ifndef NO_ASSERTIONS
  // A full skid entry implies the result register is occupied.
  a_stall_implies_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_stall_o |-> res_valid_o)
    else $error("input stalled while no result is presented");

  // The final ADC sample carries the last sample number.
  a_adc_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && last_of_packet_o && packet_kind_o == KIND_ADC
      |-> field_index_o == 6'(ADC_SAMPLES - 1))
    else $error("ADC packet ended on the wrong sample number");

  // The final block field carries index BLOCK_LAST_FIELD.
  a_block_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && last_of_packet_o && packet_kind_o == KIND_BLOCK
      |-> field_index_o == BLOCK_LAST_FIELD)
    else $error("block packet ended on the wrong field");

  // ADC samples are 16 bits wide.
  a_adc_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && packet_kind_o == KIND_ADC |-> field_value_o[63:16] == 48'd0)
    else $error("ADC sample wider than 16 bits");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_sync_packet_deframer.sv -----
// Self-checking testbench for the sync packet deframer: random idling on both sides,
// a long output hold-off, and a built-in predictor of the decoded fields.
// Depends on sdf_pkg and sync_packet_deframer.
`timescale 1ns / 1ps

module tb_sync_packet_deframer;

  import sdf_pkg::*;

  localparam int unsigned ADC_SAMPLES  = ADC_SAMPLES_DEFAULT;
  localparam int unsigned ADC_BYTES    = 2 * ADC_SAMPLES;
  localparam int unsigned RANDOM_BYTES = 280;
  localparam int unsigned HOLD_AT      = 150;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned QUIET_FROM   = 320;
  localparam int unsigned QUIET_TO     = 450;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned PRINT_LIMIT  = 40;

  // Payload fill styles for generated packets.
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ONES   = 1;
  localparam int FILL_ZEROS  = 2;
  localparam int FILL_MIXED  = 3;

  typedef enum logic [1:0] {
    HUNTING,
    IN_BLOCK,
    IN_ADC
  } parse_mode_e;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        rx_valid_i       = 1'b0;
  logic [7:0]  rx_byte_i        = 8'h00;
  logic        res_stall_i      = 1'b0;
  logic        rx_stall_o;
  logic        res_valid_o;
  logic        packet_kind_o;
  logic [5:0]  field_index_o;
  logic [63:0] field_value_o;
  logic        last_of_packet_o;

  sync_packet_deframer #(
    .ADC_SAMPLES(ADC_SAMPLES)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_valid_i      (rx_valid_i),
    .rx_stall_o      (rx_stall_o),
    .rx_byte_i       (rx_byte_i),
    .res_valid_o     (res_valid_o),
    .res_stall_i     (res_stall_i),
    .packet_kind_o   (packet_kind_o),
    .field_index_o   (field_index_o),
    .field_value_o   (field_value_o),
    .last_of_packet_o(last_of_packet_o)
  );

  always #1 clk_i = ~clk_i;

  logic [7:0]  rx_bytes_pending[$];
  sdf_result_t expected_fields[$];
  sdf_result_t oldest_field;
  int unsigned rx_total;
  int unsigned rx_accepted = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left;
  logic        hold_done;

  // Shadow copy of the deframer state.
  logic [1:0]  sync_count;
  parse_mode_e parse_mode;
  logic [6:0]  payload_pos;
  logic [63:0] field_acc;

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("mismatch at cycle %0d: %s, expected %0h, got %0h", cycle_count, what,
               want, got);
  endtask

  // Places one byte into the partial field, little-endian.
  function automatic logic [63:0] merge_byte(input logic [63:0] acc, input int unsigned pos,
                                             input logic [7:0] data);
    if (pos == 0)
      return {56'd0, data};
    return acc | ({56'd0, data} << (8 * pos));
  endfunction

  // Advances the shadow state by one byte and queues the field it completes, if any.
  task automatic deframe_byte(input logic [7:0] data);
    int unsigned off;
    int unsigned idx;
    int unsigned pos;
    int unsigned len;
    logic        done;
    sdf_result_t fld;
    off = 32'(payload_pos);
    if (parse_mode == IN_BLOCK) begin
      if (off < 24) begin
        idx = off / 8;
        pos = off % 8;
        len = 8;
      end else if (off < 28) begin
        idx = 3 + (off - 24) / 2;
        pos = (off - 24) % 2;
        len = 2;
      end else begin
        idx = 5 + off - 28;
        pos = 0;
        len = 1;
      end
      field_acc = merge_byte(field_acc, pos, data);
      done = (off + 1 >= BLOCK_BYTES);
      payload_pos = done ? 7'd0 : 7'(off + 1);
      if (done)
        parse_mode = HUNTING;
      if (pos + 1 == len) begin
        fld.packet_kind    = KIND_BLOCK;
        fld.field_index    = 6'(idx);
        fld.field_value    = field_acc;
        fld.last_of_packet = done;
        expected_fields.push_back(fld);
      end
    end else if (parse_mode == IN_ADC) begin
      pos = off % 2;
      field_acc = merge_byte(field_acc, pos, data);
      done = (off + 1 >= ADC_BYTES);
      payload_pos = done ? 7'd0 : 7'(off + 1);
      if (done)
        parse_mode = HUNTING;
      if (pos == 1) begin
        fld.packet_kind    = KIND_ADC;
        fld.field_index    = 6'(off / 2);
        fld.field_value    = {48'd0, field_acc[15:0]};
        fld.last_of_packet = done;
        expected_fields.push_back(fld);
      end
    end else if (sync_count == 2'd3) begin
      // A full header has been seen: the next byte picks the payload, or breaks the hunt.
      if (data != SYNC_BYTE)
        sync_count = 2'd0;
      if (data == TYPE_BLOCK || data == TYPE_ADC) begin
        parse_mode  = (data == TYPE_BLOCK) ? IN_BLOCK : IN_ADC;
        payload_pos = 7'd0;
        field_acc   = 64'd0;
      end
    end else begin
      sync_count = (data == SYNC_BYTE) ? sync_count + 2'd1 : 2'd0;
    end
  endtask

  // Payload byte in one of the fill styles; the mixed style is rich in header bytes.
  function automatic logic [7:0] payload_byte(input int style);
    case (style)
      FILL_ONES:  return 8'hFF;
      FILL_ZEROS: return 8'h00;
      FILL_MIXED: begin
        case ($urandom_range(0, 3))
          0: return SYNC_BYTE;
          1: return TYPE_BLOCK;
          2: return TYPE_ADC;
          default: return 8'($urandom_range(0, 255));
        endcase
      end
      default: begin
        if ($urandom_range(0, 9) == 0)
          return SYNC_BYTE;
        return 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  task automatic queue_packet(input int n_sync, input logic [7:0] kind, input int style);
    int unsigned n;
    repeat (n_sync) rx_bytes_pending.push_back(SYNC_BYTE);
    rx_bytes_pending.push_back(kind);
    n = (kind == TYPE_BLOCK) ? BLOCK_BYTES : ADC_BYTES;
    repeat (n) rx_bytes_pending.push_back(payload_byte(style));
  endtask

  // Sender: offers queued bytes, holds a stalled transfer, idles at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_valid_i <= 1'b0;
      rx_byte_i  <= 8'h00;
    end else begin
      if (rx_valid_i && !rx_stall_o) begin
        deframe_byte(rx_byte_i);
        rx_accepted <= rx_accepted + 1;
      end
      if (rx_valid_i && rx_stall_o) begin
        // The stalled transfer stays on the port unchanged.
      end else if (rx_bytes_pending.size() != 0 &&
                   ((rx_accepted >= QUIET_FROM && rx_accepted < QUIET_TO) ||
                    $urandom_range(0, 99) >= 31)) begin
        rx_valid_i <= 1'b1;
        rx_byte_i  <= rx_bytes_pending.pop_front();
      end else begin
        rx_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: one long hold-off to fill the block, random stalls outside the quiet window.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (!hold_done && rx_accepted >= HOLD_AT) begin
      res_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else if (hold_left != 0) begin
      res_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (rx_accepted >= QUIET_FROM && rx_accepted < QUIET_TO) begin
      res_stall_i <= 1'b0;
    end else begin
      res_stall_i <= ($urandom_range(0, 99) < 31);
    end
  end

  // Monitor: each result transfer is checked against the oldest predicted field.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (expected_fields.size() == 0) begin
        report_mismatch("result with none expected, value", 64'd0, field_value_o);
      end else begin
        oldest_field = expected_fields.pop_front();
        if (packet_kind_o !== oldest_field.packet_kind)
          report_mismatch("packet_kind", 64'(oldest_field.packet_kind), 64'(packet_kind_o));
        if (field_index_o !== oldest_field.field_index)
          report_mismatch("field_index", 64'(oldest_field.field_index), 64'(field_index_o));
        if (field_value_o !== oldest_field.field_value)
          report_mismatch("field_value", oldest_field.field_value, field_value_o);
        if (last_of_packet_o !== oldest_field.last_of_packet)
          report_mismatch("last_of_packet", 64'(oldest_field.last_of_packet),
                          64'(last_of_packet_o));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned target;
    sync_count  = 2'd0;
    parse_mode  = HUNTING;
    payload_pos = 7'd0;
    field_acc   = 64'd0;

    // Header probes: stray extremes, a short header, an unknown type after saturation.
    rx_bytes_pending.push_back(8'h00);
    rx_bytes_pending.push_back(8'hFF);
    rx_bytes_pending.push_back(SYNC_BYTE);
    rx_bytes_pending.push_back(SYNC_BYTE);
    rx_bytes_pending.push_back(TYPE_BLOCK);
    rx_bytes_pending.push_back(SYNC_BYTE);
    rx_bytes_pending.push_back(SYNC_BYTE);
    rx_bytes_pending.push_back(TYPE_ADC);
    repeat (4) rx_bytes_pending.push_back(SYNC_BYTE);
    rx_bytes_pending.push_back(8'h5A);
    // Extreme payloads, a saturated header, and header bytes inside a payload.
    queue_packet(5, TYPE_ADC, FILL_ONES);
    queue_packet(3, TYPE_BLOCK, FILL_ZEROS);
    rx_bytes_pending.push_back(8'h0D);
    queue_packet(3, TYPE_BLOCK, FILL_ONES);
    queue_packet(3, TYPE_ADC, FILL_MIXED);

    // Random part: mostly well-formed packets, with noise and broken headers between.
    target = rx_bytes_pending.size() + RANDOM_BYTES;
    while (rx_bytes_pending.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: queue_packet($urandom_range(3, 5), TYPE_BLOCK,
                                 ($urandom_range(0, 4) == 0) ? FILL_MIXED : FILL_RANDOM);
        4, 5, 6:    queue_packet($urandom_range(3, 4), TYPE_ADC,
                                 ($urandom_range(0, 4) == 0) ? FILL_MIXED : FILL_RANDOM);
        7: begin
          repeat ($urandom_range(1, 2)) rx_bytes_pending.push_back(SYNC_BYTE);
          rx_bytes_pending.push_back(payload_byte(FILL_MIXED));
        end
        default: begin
          repeat ($urandom_range(1, 6)) rx_bytes_pending.push_back(payload_byte(FILL_MIXED));
        end
      endcase
    end
    rx_total = rx_bytes_pending.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rx_accepted != rx_total) @(posedge clk_i);
    while (expected_fields.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_fields.size() != 0)
      report_mismatch("fields never produced", 64'(expected_fields.size()), 64'd0);

    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
